/* rtl/sap_pkg.sv */
// Shared types, constants and helper functions for the shelf atlas packer.
`default_nettype none

package sap_pkg;

   localparam int MAX_SHEET_HEIGHT = 2048;
   localparam int DIM_W            = 12;
   localparam int POS_W            = 11;
   localparam int SUM_W            = 13;
   localparam int ROW_W            = $clog2(MAX_SHEET_HEIGHT + 1);
   localparam int KIND_W           = 2;
   localparam int STATUS_W         = 2;
   localparam int CSR_IDX_W        = 1;

   localparam logic CMD_PLACE = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [KIND_W-1:0] KIND_RGBA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RGB   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_PLACED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ORDER  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SHEET_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PACK_MODE   = 1'd1;

   localparam logic [DIM_W-1:0] SHEET_WIDTH_RESET = 12'd2048;
   localparam logic             PACK_MODE_RESET   = 1'b0;

   typedef struct packed {
      logic [1:0][DIM_W-1:0] col;
      logic [1:0][ROW_W-1:0] row;
      logic [1:0][ROW_W-1:0] bottom;
      logic [1:0][DIM_W-1:0] widest;
      logic                  rgba_phase;
      logic                  fail;
      logic                  order;
   } shelf_state_type;

   typedef struct packed {
      logic              cmd;
      logic [DIM_W-1:0]  img_width;
      logic [DIM_W-1:0]  img_height;
      logic [KIND_W-1:0] frame_kind;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [STATUS_W-1:0] status;
      logic [DIM_W-1:0]    used_width;
      logic [DIM_W-1:0]    used_height;
   } result_type;

   typedef struct packed {
      logic [DIM_W-1:0] sheet_width;
      logic             pack_mode;
   } config_type;

   function automatic shelf_state_type clear_state();
      shelf_state_type s;
      s            = '0;
      s.rgba_phase = 1'b1;
      return s;
   endfunction

   function automatic logic [SUM_W-1:0] pow2_cover(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] p;
      p = SUM_W'(1) << (SUM_W - 1);
      for (int i = SUM_W - 1; i >= 0; i--) begin
         if (v <= (SUM_W'(1) << i)) begin
            p = SUM_W'(1) << i;
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

/* rtl/sap_place.sv */
// Placement logic: next shelf state and result word for one command.
`default_nettype none

module sap_place (
   input  sap_pkg::config_type      cfg,
   input  sap_pkg::shelf_state_type cur,
   input  sap_pkg::item_type        item,
   output sap_pkg::shelf_state_type nxt,
   output sap_pkg::result_type      res
);
   import sap_pkg::*;

   logic             set_sel;
   logic             mirror;
   logic             split;
   logic             bad;
   logic [DIM_W-1:0] x;
   logic [ROW_W-1:0] y;
   logic [ROW_W-1:0] bottom;
   logic [SUM_W-1:0] col_sum;
   logic [SUM_W-1:0] row_sum;
   logic [SUM_W-1:0] sheet_ext;
   logic [DIM_W-1:0] wc;
   logic [ROW_W-1:0] hb;
   logic [POS_W-1:0] px;
   logic [POS_W-1:0] py;
   logic [STATUS_W-1:0] st;

   always_comb begin
      nxt       = cur;
      px        = '0;
      py        = '0;
      st        = STATUS_PLACED;
      set_sel   = 1'b0;
      mirror    = 1'b0;
      split     = 1'b0;
      bad       = 1'b0;
      sheet_ext = SUM_W'(cfg.sheet_width);
      x         = cur.col[0];
      y         = cur.row[0];
      bottom    = cur.bottom[0];
      col_sum   = '0;
      row_sum   = '0;
      if (item.cmd == CMD_CLEAR) begin
         nxt = clear_state();
      end else if (cur.order) begin
         st = STATUS_ORDER;
      end else if (cur.fail) begin
         st = STATUS_NOFIT;
      end else begin
         if (cfg.pack_mode) begin
            case (item.frame_kind)
               KIND_RGBA: begin
                  if (cur.rgba_phase) begin
                     mirror = 1'b1;
                  end else begin
                     bad = 1'b1;
                  end
               end
               KIND_RGB: begin
                  split = 1'b1;
               end
               KIND_ALPHA: begin
                  split   = 1'b1;
                  set_sel = 1'b1;
               end
               default: begin
                  bad = 1'b1;
               end
            endcase
         end
         if (bad) begin
            nxt.order = 1'b1;
            st        = STATUS_ORDER;
         end else begin
            x       = cur.col[set_sel];
            y       = cur.row[set_sel];
            bottom  = cur.bottom[set_sel];
            col_sum = SUM_W'(x) + SUM_W'(item.img_width);
            if (col_sum > sheet_ext) begin
               x       = '0;
               y       = bottom;
               col_sum = SUM_W'(item.img_width);
            end
            row_sum = SUM_W'(y) + SUM_W'(item.img_height);
            if (col_sum > sheet_ext || row_sum > SUM_W'(MAX_SHEET_HEIGHT)) begin
               nxt.fail = 1'b1;
               st       = STATUS_NOFIT;
            end else begin
               if (split) begin
                  nxt.rgba_phase = 1'b0;
               end
               nxt.row[set_sel] = y;
               if (row_sum > SUM_W'(bottom)) begin
                  nxt.bottom[set_sel] = ROW_W'(row_sum);
               end
               nxt.col[set_sel] = DIM_W'(col_sum);
               if (DIM_W'(col_sum) > cur.widest[set_sel]) begin
                  nxt.widest[set_sel] = DIM_W'(col_sum);
               end
               if (mirror) begin
                  nxt.col[1]    = nxt.col[0];
                  nxt.row[1]    = nxt.row[0];
                  nxt.bottom[1] = nxt.bottom[0];
                  nxt.widest[1] = nxt.widest[0];
               end
               px = x[POS_W-1:0];
               py = POS_W'(y);
            end
         end
      end
   end

   assign wc = (nxt.widest[0] > nxt.widest[1]) ? nxt.widest[0] : nxt.widest[1];
   assign hb = (nxt.bottom[0] > nxt.bottom[1]) ? nxt.bottom[0] : nxt.bottom[1];

   assign res.pos_x       = px;
   assign res.pos_y       = py;
   assign res.status      = st;
   assign res.used_width  = DIM_W'(pow2_cover(SUM_W'(wc)));
   assign res.used_height = DIM_W'(pow2_cover(SUM_W'(hb)));

endmodule

`default_nettype wire

/* rtl/shelf_atlas_packer_core.sv */
// Top level of the shelf atlas packer: input stage, packing state and result register.
//
//   channel | direction | ports                                  | contents
//   req     | in        | req_tvalid/tready/tdata/tuser          | place or clear command
//   rsp     | out       | rsp_tvalid/tready/tdata/tuser          | placement and sheet size
//   csr     | in        | csr_valid/ready/index/wdata            | register writes
//
// Each command passes through the input register, then the result register, to its
// result word; a new command is accepted every cycle unless the result side stalls.
// The packing state updates when a command moves into the result register.
// Reset is synchronous and restores the register defaults and the cleared state.
// A stalled result holds the input stage, which then stalls the request side.
`default_nettype none

module shelf_atlas_packer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // img_width, img_height
   input  wire logic [2:0]  req_tuser,   // cmd, frame_kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // pos_x, pos_y, used_width, used_height, zero pad
   output logic [1:0]       rsp_tuser,   // status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [sap_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sap_pkg::DIM_W-1:0]     csr_wdata
);
   import sap_pkg::*;

   config_type      cfg_ff;
   shelf_state_type st_ff;
   shelf_state_type st_in;
   item_type        item_ff;
   item_type        item_in;
   logic            s1_valid_ff;
   logic            rsp_valid_ff;
   result_type      res_ff;
   result_type      res_in;
   logic            rsp_free;
   logic            s1_fire;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign csr_ready  = 1'b1;

   assign item_in.cmd        = req_tuser[0];
   assign item_in.frame_kind = req_tuser[2:1];
   assign item_in.img_width  = req_tdata[11:0];
   assign item_in.img_height = req_tdata[23:12];

   sap_place u_place (
      .cfg  (cfg_ff),
      .cur  (st_ff),
      .item (item_ff),
      .nxt  (st_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sheet_width <= SHEET_WIDTH_RESET;
         cfg_ff.pack_mode   <= PACK_MODE_RESET;
         st_ff              <= clear_state();
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SHEET_WIDTH: cfg_ff.sheet_width <= csr_wdata;
               REG_PACK_MODE:   cfg_ff.pack_mode   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (s1_fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = res_ff.status;
   assign rsp_tdata  = {2'b00, res_ff.used_height, res_ff.used_width,
                        res_ff.pos_y, res_ff.pos_x};

   a_clear_resets_sticky: assert property (@(posedge clock) disable iff (reset)
      s1_fire && item_ff.cmd == CMD_CLEAR |=> !st_ff.fail && !st_ff.order && st_ff.rgba_phase)
      else $error("Clear word left a sticky flag set.");

   a_order_reported: assert property (@(posedge clock) disable iff (reset)
      s1_fire && item_ff.cmd == CMD_PLACE && st_ff.order |=> res_ff.status == STATUS_ORDER)
      else $error("Place word after an order error was not reported as such.");

   a_cursor_in_widest: assert property (@(posedge clock) disable iff (reset)
      st_ff.col[0] <= st_ff.widest[0] && st_ff.col[1] <= st_ff.widest[1])
      else $error("Cursor column beyond the widest column.");

   a_row_in_shelf: assert property (@(posedge clock) disable iff (reset)
      st_ff.row[0] <= st_ff.bottom[0] && st_ff.row[1] <= st_ff.bottom[1])
      else $error("Cursor row below the shelf bottom.");

   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !$past(s1_fire) && !$past(reset) |-> $stable(st_ff))
      else $error("Packing state changed without a word.");

endmodule

`default_nettype wire
